[src/mdls_pkg.sv]
// Shared types, constants and helpers of the MESI directory line store.
`timescale 1ns / 1ps

package mdls_pkg;

    localparam int unsigned LINE_COUNT_DEF = 1024;
    localparam int unsigned LINE_BYTES     = 8;
    localparam int unsigned HOST_COUNT     = 16;

    localparam int unsigned INDEX_W   = 10;
    localparam int unsigned HOST_W    = 4;
    localparam int unsigned SIZE_W    = 4;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned TIME_W    = 64;
    localparam int unsigned SHARER_W  = 16;
    localparam int unsigned COUNT_W   = 32;
    localparam int unsigned LAT_W     = 17;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam int unsigned S_DATA_W = 152;
    localparam int unsigned M_DATA_W = 88;

    localparam logic [LAT_W:0] LAT_MAX       = 18'd131071;
    localparam logic [LAT_W:0] PENALTY_LOCAL = 18'd100;
    localparam logic [LAT_W:0] PENALTY_RDMA  = 18'd30;
    localparam logic [6:0]     RDMA_SCALE    = 7'd77;

    localparam logic [CFG_IDX_W-1:0] CFG_READ_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_BASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XFER_RATE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RDMA_MODE  = 2'd3;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_INVALID   = 2'd0,
        ST_SHARED    = 2'd1,
        ST_EXCLUSIVE = 2'd2,
        ST_MODIFIED  = 2'd3
    } mesi_t;

    typedef struct packed {
        mesi_t                 mesi;
        logic [HOST_W-1:0]     owner;
        logic [SHARER_W-1:0]   sharers;
        logic [COUNT_W-1:0]    version;
        logic [COUNT_W-1:0]    touch_count;
        logic [TIME_W-1:0]     last_time;
        logic [WORD_W-1:0]     data;
    } line_entry_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic update_wr;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_sts_t;

    // Remainder by a small constant through shifted compare-and-subtract steps.
    function automatic logic [INDEX_W-1:0] wrap_mod(input logic [INDEX_W-1:0] v,
                                                    input int unsigned d);
        logic [26:0] r;
        logic [26:0] s;
        r = 27'(v);
        for (int k = INDEX_W - 1; k >= 0; k--) begin
            s = 27'(d) << k;
            if (r >= s) begin
                r = r - s;
            end
        end
        return r[INDEX_W-1:0];
    endfunction

endpackage

[src/mdls_ctrl.sv]
// Controller state machine: clearing pass, accept and line update sequencing.
`timescale 1ns / 1ps

module mdls_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mdls_pkg::dp_sts_t sts,
    output mdls_pkg::ctl_cmd_t cmd
);
    import mdls_pkg::*;

    typedef enum logic [2:0] {
        CS_CLEAR  = 3'b001,
        CS_IDLE   = 3'b010,
        CS_UPDATE = 3'b100
    } ctl_state_t;

    ctl_state_t state_reg, state_next;

    always_comb begin
        cmd.clear_en  = (state_reg == CS_CLEAR);
        cmd.accept    = (state_reg == CS_IDLE) && s_tvalid;
        cmd.update_wr = (state_reg == CS_UPDATE) && sts.out_free;
        s_tready      = (state_reg == CS_IDLE);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_CLEAR: begin
                if (sts.clear_last) state_next = CS_IDLE;
            end
            CS_IDLE: begin
                if (s_tvalid) state_next = CS_UPDATE;
            end
            CS_UPDATE: begin
                // hold until the output register can take the result
                if (sts.out_free) state_next = CS_IDLE;
            end
            default: state_next = CS_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/mdls_datapath.sv]
// Datapath: config registers, line memories, MESI update, latency and output register.
`timescale 1ns / 1ps

module mdls_datapath #(
    parameter int unsigned LINE_COUNT = mdls_pkg::LINE_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mdls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mdls_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [mdls_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mdls_pkg::M_DATA_W-1:0] m_tdata,
    input  mdls_pkg::ctl_cmd_t            cmd,
    output mdls_pkg::dp_sts_t             sts
);
    import mdls_pkg::*;

    localparam int unsigned IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;

    // configuration
    logic [CFG_W-1:0] read_base_reg, write_base_reg, xfer_rate_reg;
    logic             rdma_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_base_reg  <= 16'd200;
            write_base_reg <= 16'd100;
            xfer_rate_reg  <= 16'd32;
            rdma_reg       <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_READ_BASE:  read_base_reg  <= cfg_wdata;
                CFG_WRITE_BASE: write_base_reg <= cfg_wdata;
                CFG_XFER_RATE:  xfer_rate_reg  <= cfg_wdata;
                CFG_RDMA_MODE:  rdma_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // input field unpack
    logic               in_cmd;
    logic [INDEX_W-1:0] in_line;
    logic [HOST_W-1:0]  in_host;
    logic [SIZE_W-1:0]  in_size;
    logic [WORD_W-1:0]  in_wword;
    logic [TIME_W-1:0]  in_tstamp;

    assign in_cmd    = s_tuser[0];
    assign in_line   = s_tdata[9:0];
    assign in_host   = s_tdata[13:10];
    assign in_size   = s_tdata[17:14];
    assign in_wword  = s_tdata[81:18];
    assign in_tstamp = s_tdata[145:82];

    logic [IDX_W-1:0]  acc_idx;
    logic [HOST_W-1:0] acc_host;
    logic [SIZE_W-1:0] acc_nbytes;
    logic [WORD_W-1:0] acc_mask;
    logic [CFG_W-1:0]  acc_base;
    logic [23:0]       base_scaled;
    logic [19:0]       xfer_q8;
    logic [24:0]       lat_q8;

    always_comb begin
        acc_idx    = IDX_W'(wrap_mod(in_line, LINE_COUNT));
        acc_host   = HOST_W'(wrap_mod(INDEX_W'(in_host), HOST_COUNT));
        acc_nbytes = (in_size < SIZE_W'(LINE_BYTES)) ? in_size : SIZE_W'(LINE_BYTES);
        for (int b = 0; b < WORD_W / 8; b++) begin
            acc_mask[8*b +: 8] = {8{SIZE_W'(b) < acc_nbytes}};
        end
        acc_base    = (in_cmd == CMD_WRITE) ? write_base_reg : read_base_reg;
        base_scaled = rdma_reg ? (24'(acc_base) * 24'(RDMA_SCALE)) : {acc_base, 8'h00};
        xfer_q8     = 20'(in_size) * 20'(xfer_rate_reg);
        lat_q8      = 25'(base_scaled) + 25'(xfer_q8);
    end

    // accepted transaction
    logic               cmd_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [HOST_W-1:0]  host_reg;
    logic [WORD_W-1:0]  mask_reg;
    logic [WORD_W-1:0]  wword_reg;
    logic [TIME_W-1:0]  tstamp_reg;
    logic [LAT_W-1:0]   lat_base_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg      <= in_cmd;
            idx_reg      <= acc_idx;
            host_reg     <= acc_host;
            mask_reg     <= acc_mask;
            wword_reg    <= in_wword;
            tstamp_reg   <= in_tstamp;
            lat_base_reg <= lat_q8[24:8];
        end
    end

    // line memories
    logic        valid_mem [LINE_COUNT];
    line_entry_t line_mem  [LINE_COUNT];
    logic        valid_rd_reg;
    line_entry_t line_rd_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    line_entry_t new_entry;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            valid_rd_reg <= valid_mem[acc_idx];
            line_rd_reg  <= line_mem[acc_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            valid_mem[clr_addr_reg] <= 1'b0;
        end else if (cmd.update_wr) begin
            valid_mem[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update_wr) begin
            line_mem[idx_reg] <= new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign sts.clear_last = (clr_addr_reg == IDX_W'(LINE_COUNT - 1));

    // MESI transition and latency
    line_entry_t       old_entry;
    logic [SHARER_W-1:0] hbit;
    logic [WORD_W-1:0] rword;
    logic [LAT_W:0]    lat_sum;
    logic [LAT_W-1:0]  lat_final;

    always_comb begin
        // first touch reads as a cleared line
        old_entry = valid_rd_reg ? line_rd_reg : '0;
        hbit      = SHARER_W'(1) << host_reg;
        new_entry = old_entry;
        rword     = '0;
        if (cmd_reg == CMD_WRITE) begin
            if (old_entry.mesi != ST_MODIFIED || old_entry.owner != host_reg) begin
                new_entry.mesi    = ST_MODIFIED;
                new_entry.owner   = host_reg;
                new_entry.sharers = hbit;
            end
            new_entry.data = (old_entry.data & ~mask_reg) | (wword_reg & mask_reg);
        end else begin
            priority if (old_entry.mesi == ST_INVALID) begin
                new_entry.mesi    = ST_EXCLUSIVE;
                new_entry.owner   = host_reg;
                new_entry.sharers = hbit;
            end else if (old_entry.mesi == ST_SHARED) begin
                new_entry.sharers = old_entry.sharers | hbit;
            end else if (old_entry.owner != host_reg) begin
                new_entry.mesi    = ST_SHARED;
                new_entry.sharers = old_entry.sharers | hbit;
            end else begin
                new_entry.mesi = old_entry.mesi;
            end
            rword = old_entry.data & mask_reg;
        end
        new_entry.version     = old_entry.version + 1'b1;
        new_entry.touch_count = old_entry.touch_count + 1'b1;
        new_entry.last_time   = tstamp_reg;

        lat_sum = {1'b0, lat_base_reg};
        if (cmd_reg == CMD_WRITE && old_entry.mesi == ST_SHARED) begin
            lat_sum = lat_sum + (rdma_reg ? PENALTY_RDMA : PENALTY_LOCAL);
        end
        lat_final = (lat_sum > LAT_MAX) ? LAT_MAX[LAT_W-1:0] : lat_sum[LAT_W-1:0];
    end

    // output register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    assign sts.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.update_wr) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update_wr) begin
            out_data_reg <= {5'd0, lat_final, new_entry.mesi, rword};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[src/mesi_directory_line_store_unit.sv]
// Each transaction is handled as an accept with memory read, then an update and result load.
// The result shows on m_tvalid once the update step has loaded it into the output register.
// A new transaction waits for the last update, set by the read-modify-write of the line memory.
// A full output register stalls the update step until the result is taken.
// After reset a clearing pass over every line zeroes the valid store; s_tready stays
// low meanwhile, while configuration writes are taken; reset sets the registers to defaults.
`timescale 1ns / 1ps

module mesi_directory_line_store_unit #(
    parameter int unsigned LINE_COUNT = mdls_pkg::LINE_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mdls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mdls_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // line_index[9:0], host_id[13:10], size_bytes[17:14], write_word[81:18],
    // timestamp[145:82], zero fill
    input  logic [mdls_pkg::S_DATA_W-1:0]  s_tdata,
    // command[0]
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_word[63:0], line_state[65:64], latency[82:66], zero fill
    output logic [mdls_pkg::M_DATA_W-1:0]  m_tdata
);
    import mdls_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    mdls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mdls_datapath #(
        .LINE_COUNT (LINE_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[src/mdls_checker.sv]
// Port-level checker of the MESI directory line store, bound to the top level.
`timescale 1ns / 1ps

module mdls_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mdls_pkg::M_DATA_W-1:0]  m_tdata
);
    import mdls_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one transaction at a time: no accept right after an accept
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during line update");

    // a fresh result only follows an accept, through the update state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without accepted transaction");

    // every access leaves the line in a valid coherence state
    a_state_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[65:64] != ST_INVALID)
        else $error("result reports invalid line state");

    // coming out of reset: clearing pass, no result pending
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_tready && !m_tvalid)
        else $error("activity right after reset");

endmodule

bind mesi_directory_line_store_unit mdls_checker u_mdls_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/tb_mesi_directory_line_store_unit.sv]
// Self-checking testbench for the MESI directory line store: directed and random accesses.
`timescale 1ns / 1ps

module tb_mesi_directory_line_store_unit;

    import mdls_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        mesi_t             state;
        logic [LAT_W-1:0]  lat;
    } access_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // Directory shadow of the block
    logic                  dir_valid   [0:LINE_COUNT_DEF-1];
    mesi_t                 dir_state   [0:LINE_COUNT_DEF-1];
    logic [HOST_W-1:0]     dir_owner   [0:LINE_COUNT_DEF-1];
    logic [SHARER_W-1:0]   dir_sharers [0:LINE_COUNT_DEF-1];
    logic [WORD_W-1:0]     dir_word    [0:LINE_COUNT_DEF-1];

    logic [CFG_W-1:0]      rd_base;
    logic [CFG_W-1:0]      wr_base;
    logic [CFG_W-1:0]      xfer_rate;
    logic                  rdma_on;

    access_result_t        pending_results[$];
    int                    error_count = 0;
    bit                    src_idle_on = 0;
    bit                    sink_stall_on = 0;
    int                    sink_hold = 0;
    int                    hot_line[6];

    mesi_directory_line_store_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Apply one directory access to the shadow and queue its result
    task automatic predict_access(input logic cmd, input logic [INDEX_W-1:0] idx,
                                  input logic [HOST_W-1:0] host,
                                  input logic [SIZE_W-1:0] size,
                                  input logic [WORD_W-1:0] wword);
        access_result_t      r;
        mesi_t               prev;
        logic [WORD_W-1:0]   mask;
        logic [SHARER_W-1:0] hbit;
        logic [CFG_W-1:0]    base;
        logic [31:0]         q8;
        logic [31:0]         lat;
        if (!dir_valid[idx]) begin
            dir_valid[idx]   = 1'b1;
            dir_state[idx]   = ST_INVALID;
            dir_owner[idx]   = '0;
            dir_sharers[idx] = '0;
            dir_word[idx]    = '0;
        end
        mask = (size >= 4'd8) ? {WORD_W{1'b1}} : (64'h1 << {size, 3'b000}) - 64'h1;
        hbit = 16'h1 << host;
        prev = dir_state[idx];
        r.state = prev;
        r.word = '0;
        if (cmd == CMD_WRITE) begin
            if (prev != ST_MODIFIED || dir_owner[idx] != host) begin
                r.state = ST_MODIFIED;
                dir_owner[idx] = host;
                dir_sharers[idx] = hbit;
            end
        end else begin
            unique case (prev)
                ST_INVALID: begin
                    r.state = ST_EXCLUSIVE;
                    dir_owner[idx] = host;
                    dir_sharers[idx] = hbit;
                end
                ST_SHARED: begin
                    dir_sharers[idx] = dir_sharers[idx] | hbit;
                end
                default: begin
                    if (dir_owner[idx] != host) begin
                        r.state = ST_SHARED;
                        dir_sharers[idx] = dir_sharers[idx] | hbit;
                    end
                end
            endcase
        end
        dir_state[idx] = r.state;
        if (cmd == CMD_WRITE) begin
            dir_word[idx] = (dir_word[idx] & ~mask) | (wword & mask);
        end else begin
            r.word = dir_word[idx] & mask;
        end
        base = (cmd == CMD_WRITE) ? wr_base : rd_base;
        q8 = rdma_on ? {16'h0, base} * 32'd77 : {8'h0, base, 8'h00};
        q8 = q8 + {28'h0, size} * {16'h0, xfer_rate};
        lat = q8 >> 8;
        // upgrade from Shared costs an invalidation round
        if (cmd == CMD_WRITE && prev == ST_SHARED) begin
            lat = lat + (rdma_on ? 32'd30 : 32'd100);
        end
        if (lat > 32'd131071) begin
            lat = 32'd131071;
        end
        r.lat = lat[LAT_W-1:0];
        pending_results = {pending_results, r};
    endtask

    task automatic send_access(input logic cmd, input logic [INDEX_W-1:0] idx,
                               input logic [HOST_W-1:0] host,
                               input logic [SIZE_W-1:0] size,
                               input logic [WORD_W-1:0] wword,
                               input logic [TIME_W-1:0] tstamp);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'h0, tstamp, wword, size, host, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_access(cmd, idx, host, size, wword);
        gap = (src_idle_on && $urandom_range(0, 99) < 40) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random_access();
        logic              cmd;
        logic [INDEX_W-1:0] idx;
        logic [HOST_W-1:0] host;
        logic [SIZE_W-1:0] size;
        cmd  = 1'($urandom_range(0, 1));
        idx  = ($urandom_range(0, 3) != 0) ? INDEX_W'(hot_line[$urandom_range(0, 5)])
                                           : INDEX_W'($urandom_range(0, LINE_COUNT_DEF - 1));
        host = ($urandom_range(0, 9) < 7) ? HOST_W'($urandom_range(0, 2))
                                          : HOST_W'($urandom_range(0, 15));
        size = ($urandom_range(0, 9) < 7) ? SIZE_W'($urandom_range(0, 8))
                                          : SIZE_W'($urandom_range(0, 15));
        send_access(cmd, idx, host, size, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic pick_hot_lines();
        foreach (hot_line[i]) begin
            hot_line[i] = $urandom_range(0, LINE_COUNT_DEF - 1);
        end
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] wb,
                                input logic [CFG_W-1:0] rate, input logic rdma);
        logic [CFG_W-2:0] junk;
        junk = (CFG_W-1)'($urandom);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_READ_BASE;
        cfg_wdata <= rb;
        @(posedge aclk);
        cfg_index <= CFG_WRITE_BASE;
        cfg_wdata <= wb;
        @(posedge aclk);
        cfg_index <= CFG_XFER_RATE;
        cfg_wdata <= rate;
        @(posedge aclk);
        // upper bits of the mode register are don't-care
        cfg_index <= CFG_RDMA_MODE;
        cfg_wdata <= {junk, rdma};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        rd_base   = rb;
        wr_base   = wb;
        xfer_rate = rate;
        rdma_on   = rdma;
    endtask

    task automatic test_directed_transitions();
        src_idle_on   = 0;
        sink_stall_on = 0;
        send_access(CMD_READ,  10'd0,    4'd3,  4'd8,  64'h0,                 64'h1);
        send_access(CMD_READ,  10'd0,    4'd3,  4'd8,  64'h0,                 64'h2);
        send_access(CMD_READ,  10'd0,    4'd5,  4'd8,  64'h0,                 64'h3);
        send_access(CMD_WRITE, 10'd0,    4'd5,  4'd8,  64'h0123456789abcdef,  64'h4);
        send_access(CMD_WRITE, 10'd0,    4'd5,  4'd3,  64'hfedcba9876543210,  64'h5);
        send_access(CMD_READ,  10'd0,    4'd5,  4'd8,  64'h0,                 64'h6);
        send_access(CMD_WRITE, 10'd0,    4'd9,  4'd15, 64'h5a5a_a5a5_0ff0_f00f, 64'h7);
        send_access(CMD_READ,  10'd0,    4'd2,  4'd4,  64'h0,                 64'h8);
        send_access(CMD_READ,  10'd0,    4'd7,  4'd0,  64'h0,                 64'h9);
        send_access(CMD_WRITE, 10'd1023, 4'd15, 4'd8,  {WORD_W{1'b1}},        {TIME_W{1'b1}});
        send_access(CMD_READ,  10'd1023, 4'd0,  4'd15, 64'h0,                 64'h0);
        send_access(CMD_WRITE, 10'd1023, 4'd0,  4'd0,  64'h0,                 64'ha);
        send_access(CMD_READ,  10'd1023, 4'd15, 4'd9,  64'h0,                 64'hb);
        send_access(CMD_WRITE, 10'd512,  4'd0,  4'd1,  64'h8000_0000_0000_00ff, 64'hc);
        send_access(CMD_READ,  10'd512,  4'd0,  4'd7,  {WORD_W{1'b1}},        64'hd);
        send_access(CMD_READ,  10'd1,    4'd0,  4'd8,  {WORD_W{1'b1}},        64'he);
        send_access(CMD_WRITE, 10'd1,    4'd8,  4'd4,  64'hdead_beef_cafe_f00d, 64'h0);
        send_access(CMD_READ,  10'd1,    4'd12, 4'd5,  64'h0,                 64'hf);
    endtask

    task automatic test_random_defaults();
        src_idle_on   = 1;
        sink_stall_on = 1;
        pick_hot_lines();
        repeat (150) send_random_access();
    endtask

    task automatic test_register_extremes();
        program_regs(16'h0, 16'h0, 16'h0, 1'b0);
        pick_hot_lines();
        repeat (60) send_random_access();
        program_regs(16'hffff, 16'hffff, 16'hffff, 1'b1);
        repeat (60) send_random_access();
        program_regs(16'hffff, 16'hffff, 16'hffff, 1'b0);
        pick_hot_lines();
        repeat (60) send_random_access();
    endtask

    task automatic test_rdma_mode();
        program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 1'b1);
        pick_hot_lines();
        repeat (150) send_random_access();
    endtask

    task automatic test_back_to_back();
        program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                     1'($urandom_range(0, 1)));
        src_idle_on   = 0;
        sink_stall_on = 0;
        pick_hot_lines();
        repeat (150) send_random_access();
    endtask

    // Result sink: random stalls on m_tready while sink_stall_on is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold != 0) begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (sink_stall_on && $urandom_range(0, 99) < 30) begin
                sink_hold <= idle_len();
            end
        end
    end

    // Compare each result transaction with the oldest queued prediction
    always @(posedge aclk) begin
        access_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[63:0] !== want.word) begin
                    report_mismatch("read_word", m_tdata[63:0], want.word);
                end
                if (m_tdata[65:64] !== want.state) begin
                    report_mismatch("line_state", WORD_W'(m_tdata[65:64]),
                                    WORD_W'(want.state));
                end
                if (m_tdata[82:66] !== want.lat) begin
                    report_mismatch("latency", WORD_W'(m_tdata[82:66]), WORD_W'(want.lat));
                end
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_READ_BASE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_READ;
        for (int i = 0; i < LINE_COUNT_DEF; i++) begin
            dir_valid[i] = 1'b0;
        end
        rd_base   = 16'd200;
        wr_base   = 16'd100;
        xfer_rate = 16'd32;
        rdma_on   = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        // hold until the clearing pass is over
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);

        test_directed_transitions();
        test_random_defaults();
        test_register_extremes();
        test_rdma_mode();
        test_back_to_back();

        wait_idle();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("** mesi_directory_line_store_unit: PASSED **");
        end else begin
            $display("** mesi_directory_line_store_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("** mesi_directory_line_store_unit: FAILED **");
        $finish;
    end

endmodule

[mesi_directory_line_store_unit.f]
src/mdls_pkg.sv
src/mdls_ctrl.sv
src/mdls_datapath.sv
src/mesi_directory_line_store_unit.sv
src/mdls_checker.sv
sim/tb_mesi_directory_line_store_unit.sv
